// ===== design/sia_pkg.sv =====
package sia_pkg;

  // Build-time defaults for the top-level parameters
  localparam int POOL_SIZE_DEF = 1024;
  localparam int MAX_BATCH_DEF = 16;

  // Fixed field widths of the request and result channels
  localparam int ID_OUT_W   = 10;
  localparam int CNT_OUT_W  = 11;
  localparam int BATCH_IN_W = 5;

  // Width wide enough to compare any id, count or limit at the largest pool
  localparam int CMP_W = 17;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LIVE_ADDR = 2'd0;
  localparam logic [CNT_OUT_W-1:0]  MAX_LIVE_RESET    = 11'd1024;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NEVER     = 2'd2;
  localparam logic [1:0] STATUS_NOT_ALLOC = 2'd3;

  typedef struct packed {
    logic                  mode;
    logic [BATCH_IN_W-1:0] batch_count;
    logic [ID_OUT_W-1:0]   free_id;
  } in_req_t;

  typedef struct packed {
    logic [ID_OUT_W-1:0]  granted_id;
    logic [1:0]           status;
    logic                 last;
    logic [CNT_OUT_W-1:0] live_count;
  } out_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_WB,
    S_FREE_WB,
    S_FULL
  } eng_state_t;

endpackage

// ===== design/sia_cfg.sv =====
module sia_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sia_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sia_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sia_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [sia_pkg::CNT_OUT_W-1:0]   max_live
);
  import sia_pkg::*;

  logic [CNT_OUT_W-1:0] max_live_r;
  logic                 wr_hit;

  assign pready   = 1'b1;
  assign wr_hit   = psel && penable && pwrite && (paddr == REG_MAX_LIVE_ADDR);
  assign max_live = max_live_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_live_r <= MAX_LIVE_RESET;
    end else if (wr_hit) begin
      max_live_r <= pwdata[CNT_OUT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_MAX_LIVE_ADDR) begin
      prdata = CFG_DATA_W'(max_live_r);
    end
  end

endmodule

// ===== design/sia_out_buf.sv =====
module sia_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  sia_pkg::out_res_t res,
  output logic              res_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output sia_pkg::out_res_t out_data
);
  import sia_pkg::*;

  logic     full_r;
  out_res_t data_r;

  // Take a new result when empty or when the held one leaves this cycle
  assign res_ready = !full_r || !out_stall;
  assign out_valid = full_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (res_ready) begin
      full_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

endmodule

// ===== design/sia_engine.sv =====
module sia_engine #(
  parameter int POOL_SIZE = sia_pkg::POOL_SIZE_DEF,
  parameter int MAX_BATCH = sia_pkg::MAX_BATCH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sia_pkg::in_req_t              in_data,
  input  logic [sia_pkg::CNT_OUT_W-1:0] max_live,
  output logic                          res_valid,
  output sia_pkg::out_res_t             res,
  input  logic                          res_ready
);
  import sia_pkg::*;

  localparam int ID_W    = $clog2(POOL_SIZE);
  localparam int CNT_W   = $clog2(POOL_SIZE + 1);
  localparam int BATCH_W = $clog2(MAX_BATCH + 1);
  localparam logic [CMP_W-1:0]   POOL_C  = CMP_W'(POOL_SIZE);
  localparam logic [CMP_W-1:0]   BATCH_C = CMP_W'(MAX_BATCH);
  localparam logic [BATCH_W-1:0] ONE_B   = BATCH_W'(1);

  // Memories: LIFO of freed ids and one valid bit per id
  logic [ID_W-1:0] stk_mem [POOL_SIZE];
  logic            vld_mem [POOL_SIZE];
  logic [ID_W-1:0] stk_q_r;
  logic            vld_q_r;

  logic            stk_rd_en, stk_wr_en, vld_rd_en, vld_wr_en, vld_wr_data;
  logic [ID_W-1:0] stk_rd_addr, stk_wr_addr, stk_wr_data, vld_rd_addr, vld_wr_addr;

  eng_state_t state_r, state_nxt;

  logic [CNT_W-1:0]    high_r, depth_r;
  logic [BATCH_W-1:0]  remain_r;
  logic [ID_OUT_W-1:0] fid_r;

  logic                fire;
  logic [CNT_W-1:0]    live_now, depth_m1;
  logic [CMP_W-1:0]    live_ext, high_ext, max_ext, limit_ext, batch_ext, cnt_sat;
  logic [CMP_W-1:0]    fid_in_ext, fid_r_ext, alloc_id_ext, live_out_ext;
  logic                full_hit, stk_hit, never_issued;
  logic [ID_W-1:0]     alloc_id;
  logic [CNT_W-1:0]    live_out;

  assign fire     = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  assign live_now   = high_r - depth_r;
  assign depth_m1   = depth_r - CNT_W'(1);
  assign live_ext   = CMP_W'(live_now);
  assign high_ext   = CMP_W'(high_r);
  assign max_ext    = CMP_W'(max_live);
  assign limit_ext  = (max_ext > POOL_C) ? POOL_C : max_ext;
  assign batch_ext  = CMP_W'(in_data.batch_count);
  assign cnt_sat    = (batch_ext > BATCH_C) ? BATCH_C : batch_ext;
  assign full_hit   = (live_ext + cnt_sat) > limit_ext;

  assign stk_hit      = (depth_r != '0);
  assign alloc_id     = stk_hit ? stk_q_r : high_r[ID_W-1:0];
  assign alloc_id_ext = CMP_W'(alloc_id);

  assign fid_in_ext   = CMP_W'(in_data.free_id);
  assign fid_r_ext    = CMP_W'(fid_r);
  assign never_issued = (fid_r_ext >= high_ext) || (fid_r_ext >= POOL_C);

  assign live_out_ext = CMP_W'(live_out);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (fire) begin
          if (in_data.mode == MODE_FREE) begin
            state_nxt = S_FREE_WB;
          end else if (cnt_sat == '0) begin
            state_nxt = S_IDLE;
          end else if (full_hit) begin
            state_nxt = S_FULL;
          end else begin
            state_nxt = S_ALLOC_RD;
          end
        end
      end
      S_ALLOC_RD: state_nxt = S_ALLOC_WB;
      S_ALLOC_WB: begin
        if (res_ready) begin
          state_nxt = (remain_r == ONE_B) ? S_IDLE : S_ALLOC_RD;
        end
      end
      S_FREE_WB, S_FULL: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and memory requests
  always_comb begin
    res_valid   = 1'b0;
    res         = '0;
    live_out    = live_now;
    stk_rd_en   = 1'b0;
    stk_rd_addr = depth_m1[ID_W-1:0];
    stk_wr_en   = 1'b0;
    stk_wr_addr = depth_r[ID_W-1:0];
    stk_wr_data = fid_r_ext[ID_W-1:0];
    vld_rd_en   = 1'b0;
    vld_rd_addr = fid_in_ext[ID_W-1:0];
    vld_wr_en   = 1'b0;
    vld_wr_addr = fid_r_ext[ID_W-1:0];
    vld_wr_data = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        vld_rd_en = fire && (in_data.mode == MODE_FREE);
      end
      S_ALLOC_RD: begin
        stk_rd_en = stk_hit;
      end
      S_ALLOC_WB: begin
        live_out       = live_now + CNT_W'(1);
        res_valid      = 1'b1;
        res.granted_id = alloc_id_ext[ID_OUT_W-1:0];
        res.status     = STATUS_OK;
        res.last       = (remain_r == ONE_B);
        vld_wr_en      = res_ready;
        vld_wr_addr    = alloc_id;
        vld_wr_data    = 1'b1;
      end
      S_FREE_WB: begin
        res_valid      = 1'b1;
        res.granted_id = fid_r;
        res.last       = 1'b1;
        if (never_issued) begin
          res.status = STATUS_NEVER;
        end else if (!vld_q_r) begin
          res.status = STATUS_NOT_ALLOC;
        end else begin
          res.status = STATUS_OK;
          live_out   = live_now - CNT_W'(1);
          vld_wr_en  = res_ready;
          stk_wr_en  = res_ready;
        end
      end
      S_FULL: begin
        res_valid      = 1'b1;
        res.granted_id = '0;
        res.status     = STATUS_FULL;
        res.last       = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    res.live_count = live_out_ext[CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r  <= '0;
      depth_r <= '0;
    end else begin
      if (state_r == S_ALLOC_WB && res_ready) begin
        if (stk_hit) begin
          depth_r <= depth_m1;
        end else begin
          high_r <= high_r + CNT_W'(1);
        end
      end
      if (stk_wr_en) begin
        depth_r <= depth_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      remain_r <= cnt_sat[BATCH_W-1:0];
      fid_r    <= in_data.free_id;
    end else if (state_r == S_ALLOC_WB && res_ready) begin
      remain_r <= remain_r - ONE_B;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stk_mem[stk_wr_addr] <= stk_wr_data;
    end
    if (stk_rd_en) begin
      stk_q_r <= stk_mem[stk_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (vld_wr_en) begin
      vld_mem[vld_wr_addr] <= vld_wr_data;
    end
    if (vld_rd_en) begin
      vld_q_r <= vld_mem[vld_rd_addr];
    end
  end

  a_depth_le_high: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= high_r)
    else $error("free stack deeper than issued id count");

  a_high_le_pool: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(high_r) <= POOL_C)
    else $error("issued id count beyond pool size");

  a_wb_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC_WB) |->
      ($past(state_r) == S_ALLOC_RD || $past(state_r) == S_ALLOC_WB))
    else $error("grant write-back without a preceding stack read");

  a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FULL) |=> ($stable(high_r) && $stable(depth_r)))
    else $error("pool-full request changed allocator state");

endmodule

// ===== design/slot_id_allocator_lifo_free_list.sv =====
// Free request: the valid bit is read on accept, then S_FREE_WB passes the result to the output
// buffer. Allocate request of N ids: each id is read from the stack in S_ALLOC_RD or freshly
// issued, then its valid bit is written in S_ALLOC_WB; pool full answers from S_FULL and an
// empty batch gives no answer. A new request is accepted only once the FSM is back in S_IDLE.
// Synchronous active-low reset clears the high mark, stack depth, FSM and output buffer
// and sets max_live to 1024; stack and valid memories are not cleared (no clearing pass).
module slot_id_allocator_lifo_free_list #(
  parameter int POOL_SIZE = sia_pkg::POOL_SIZE_DEF,
  parameter int MAX_BATCH = sia_pkg::MAX_BATCH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sia_pkg::in_req_t               in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output sia_pkg::out_res_t              out_data,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sia_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sia_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sia_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sia_pkg::*;

  logic [CNT_OUT_W-1:0] max_live;
  logic                 res_valid;
  logic                 res_ready;
  out_res_t             res;

  // Hold live-id limit; unenforced user rule: written only while the allocator is idle
  sia_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .max_live (max_live)
  );

  // Sequence each request: check the limit, pop or mint ids, check and push freed ids.
  // The engine owns the free stack and valid-bit memories; every access is
  // serialized by its FSM, so no read ever meets a write to the same entry.
  sia_engine #(
    .POOL_SIZE (POOL_SIZE),
    .MAX_BATCH (MAX_BATCH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .max_live  (max_live),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Decouple the result channel so a stalled result does not block the next request
  sia_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== dv/slot_id_allocator_lifo_free_list_tb.sv =====
module slot_id_allocator_lifo_free_list_tb;
  import sia_pkg::*;

  // Clock half period and run limit in time units; reset and drain lengths in clock cycles
  localparam int  CLK_HALF    = 4;
  localparam int  RESET_LEN   = 9;
  // Longest own work of one request is a full batch of 16 ids; allow margin on top
  localparam int  DRAIN_CYC   = 48;
  localparam int  PHASE_ITEMS = 40;
  localparam int  NUM_PHASES  = 5;
  localparam longint RUN_LIMIT = 64'd20_000_000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_res_t out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow of the allocator: limit register, high mark, stack and live bits
  logic [CNT_OUT_W-1:0] shadow_limit;
  int unsigned          shadow_high_mark;
  int unsigned          shadow_depth;
  bit                   shadow_live [POOL_SIZE_DEF];
  logic [ID_OUT_W-1:0]  shadow_stack [POOL_SIZE_DEF];

  // Grants (and free and pool-full answers) still owed by the block, oldest first
  out_res_t expected_grants[$];

  // Shared controls for the two idling processes
  bit          no_idle;
  int unsigned sink_hold_cycles;

  int unsigned errors;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_full;
  int unsigned n_rejected_frees;

  slot_id_allocator_lifo_free_list u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  // Queue one expected answer; live count is taken after the state update
  function automatic void owe_grant(input int unsigned id, input logic [1:0] st,
                                    input bit is_last);
    out_res_t r;
    r.granted_id = id[ID_OUT_W-1:0];
    r.status     = st;
    r.last       = is_last;
    r.live_count = CNT_OUT_W'(shadow_high_mark - shadow_depth);
    expected_grants = {expected_grants, r};
  endfunction

  // Apply one accepted request to the shadow and queue what it must produce
  task automatic predict_grants(input in_req_t req);
    int unsigned want;
    int unsigned cap;
    int unsigned id;
    begin
      if (req.mode == MODE_ALLOC) begin
        want = req.batch_count;
        if (want > MAX_BATCH_DEF) want = MAX_BATCH_DEF;
        cap = shadow_limit;
        if (cap > POOL_SIZE_DEF) cap = POOL_SIZE_DEF;
        if (want == 0) return;
        // All-or-nothing: a batch that does not fit changes nothing
        if (shadow_high_mark - shadow_depth + want > cap) begin
          owe_grant(0, STATUS_FULL, 1'b1);
          return;
        end
        for (int i = 0; i < want; i++) begin
          // Reuse the most recently freed id first, else issue a fresh one
          if (shadow_depth > 0) begin
            shadow_depth--;
            id = shadow_stack[shadow_depth % POOL_SIZE_DEF];
          end else begin
            id = shadow_high_mark;
            shadow_high_mark++;
          end
          if (id < POOL_SIZE_DEF) shadow_live[id] = 1'b1;
          owe_grant(id, STATUS_OK, (i + 1 == want));
        end
      end else begin
        id = req.free_id;
        if (id >= shadow_high_mark) begin
          owe_grant(id, STATUS_NEVER, 1'b1);
          return;
        end
        if (!shadow_live[id]) begin
          owe_grant(id, STATUS_NOT_ALLOC, 1'b1);
          return;
        end
        shadow_live[id] = 1'b0;
        if (shadow_depth < POOL_SIZE_DEF) begin
          shadow_stack[shadow_depth] = id[ID_OUT_W-1:0];
          shadow_depth++;
        end
        owe_grant(id, STATUS_OK, 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one request, hold it until accepted, then return on the next
  // falling edge with valid still high so a back-to-back request can follow
  task automatic send_request(input in_req_t req);
    int unsigned gap;
    begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid = 1'b1;
      in_data  = req;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      predict_grants(req);
      n_requests++;
      @(negedge clk);
    end
  endtask

  function automatic in_req_t make_alloc(input int unsigned n);
    in_req_t r;
    r.mode        = MODE_ALLOC;
    r.batch_count = n[BATCH_IN_W-1:0];
    r.free_id     = ID_OUT_W'($urandom);
    return r;
  endfunction

  function automatic in_req_t make_free(input int unsigned id);
    in_req_t r;
    r.mode        = MODE_FREE;
    r.batch_count = BATCH_IN_W'($urandom);
    r.free_id     = id[ID_OUT_W-1:0];
    return r;
  endfunction

  // Return some currently allocated id, or -1 when none is live
  function automatic int find_live_id();
    int unsigned start;
    int unsigned id;
    if (shadow_high_mark == 0) return -1;
    start = $urandom_range(0, shadow_high_mark - 1);
    for (int k = 0; k < shadow_high_mark; k++) begin
      id = (start + k) % shadow_high_mark;
      if (shadow_live[id]) return id;
    end
    return -1;
  endfunction

  // Mostly well-formed traffic: batches that fit and frees of live ids;
  // the rest is double frees, frees of unissued ids and odd batch sizes
  function automatic in_req_t random_request();
    int unsigned r;
    int          id;
    r = $urandom_range(0, 99);
    if (r < 30) return make_alloc($urandom_range(1, 8));
    if (r < 40) return make_alloc($urandom_range(9, 16));
    if (r < 45) return make_alloc($urandom_range(17, 31));
    if (r < 47) return make_alloc(0);
    if (r < 85) begin
      id = find_live_id();
      if (id < 0) return make_alloc($urandom_range(1, 16));
      return make_free(id);
    end
    if (r < 92 && shadow_depth > 0)
      return make_free(shadow_stack[shadow_depth - 1]);
    return make_free($urandom_range(0, POOL_SIZE_DEF - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  // Write the limit register, then read it back; only called while idle
  task automatic write_limit(input logic [CNT_OUT_W-1:0] value);
    begin
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = REG_MAX_LIVE_ADDR;
      pwdata  = CFG_DATA_W'(value);
      @(negedge clk);
      penable = 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      shadow_limit = value;
      @(negedge clk);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clk);
      penable = 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (prdata[CNT_OUT_W-1:0] !== value) begin
        $display("%0t: limit readback mismatch: expected %0d actual %0d",
                 $time, value, prdata[CNT_OUT_W-1:0]);
        errors++;
      end
      @(negedge clk);
      psel    = 1'b0;
      penable = 1'b0;
    end
  endtask

  // Drop valid, wait for every owed answer, then let any empty batch still
  // in the engine finish before the caller touches the register
  task automatic wait_idle();
    begin
      in_valid = 1'b0;
      while (expected_grants.size() != 0) @(negedge clk);
      repeat (DRAIN_CYC) @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall with occasional long holds
  // ---------------------------------------------------------------------------

  initial begin : sink_stall_proc
    int unsigned burst;
    int unsigned r;
    burst     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        // Pressure hold: keep the sink closed so the block backs up
        out_stall = 1'b1;
        sink_hold_cycles--;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if (no_idle) begin
        out_stall = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall = 1'b0;
        end else if (r < 97) begin
          out_stall = 1'b1;
          burst = $urandom_range(0, 2);
        end else begin
          out_stall = 1'b1;
          burst = $urandom_range(10, 40);
        end
      end
    end
  end

  // Compare every accepted result with the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_data.status == STATUS_FULL) n_full++;
      if (out_data.status == STATUS_NEVER || out_data.status == STATUS_NOT_ALLOC)
        n_rejected_frees++;
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result: id %0d status %0d last %0d live %0d",
                 $time, out_data.granted_id, out_data.status, out_data.last,
                 out_data.live_count);
        errors++;
      end else begin : compare_one
        out_res_t exp_r;
        exp_r = expected_grants.pop_front();
        if (out_data.granted_id !== exp_r.granted_id ||
            out_data.status     !== exp_r.status     ||
            out_data.last       !== exp_r.last       ||
            out_data.live_count !== exp_r.live_count) begin
          $display("%0t: result mismatch: expected id %0d status %0d last %0d live %0d",
                   $time, exp_r.granted_id, exp_r.status, exp_r.last, exp_r.live_count);
          $display("%0t:                  actual   id %0d status %0d last %0d live %0d",
                   $time, out_data.granted_id, out_data.status, out_data.last,
                   out_data.live_count);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Each operation, the batch edge sizes and both free errors
  task automatic test_basic_ops();
    begin
      send_request(make_alloc(0));        // empty batch: no answer at all
      send_request(make_free(0));         // nothing issued yet
      send_request(make_alloc(1));        // fresh id 0
      send_request(make_alloc(16));       // largest batch
      send_request(make_alloc(31));       // saturates to the largest batch
      send_request(make_free(5));
      send_request(make_free(5));         // double free
      send_request(make_free(1023));      // top id, never issued
      send_request(make_free(20));
      send_request(make_free(7));
      send_request(make_alloc(2));        // pops 7 then 20
      send_request(make_alloc(3));        // pops 5 then two fresh ids
      wait_idle();
    end
  endtask

  // Lower the limit below the live count, then a zero and an oversized limit
  task automatic test_limit_edges();
    begin
      write_limit(11'd4);
      send_request(make_alloc(1));        // full
      send_request(make_free(0));         // frees still work
      send_request(make_alloc(1));        // still full
      wait_idle();
      write_limit(11'd0);
      send_request(make_alloc(1));
      wait_idle();
      write_limit(11'd2047);              // acts as the pool size
      send_request(make_alloc(3));
      send_request(make_alloc(0));
      wait_idle();
    end
  endtask

  // Close the sink for a long stretch while large batches keep coming
  task automatic test_backpressure();
    begin
      no_idle = 1'b1;
      sink_hold_cycles = 300;
      for (int i = 0; i < 8; i++) send_request(make_alloc(16));
      for (int i = 0; i < 6; i++) send_request(make_free(find_live_id()));
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  // Random phases, each under its own limit; some phases run without gaps
  task automatic test_random_traffic();
    int unsigned live;
    int unsigned taken;
    in_req_t     req;
    begin
      for (int p = 0; p < NUM_PHASES; p++) begin
        live = shadow_high_mark - shadow_depth;
        case (p)
          0: write_limit(CNT_OUT_W'(live + $urandom_range(0, 30)));
          1: write_limit(11'd1024);
          2: write_limit(CNT_OUT_W'(live + $urandom_range(20, 60)));
          3: write_limit(11'd2047);
          default: write_limit(CNT_OUT_W'($urandom_range(0, 2047)));
        endcase
        no_idle = (p % 2 == 1);
        taken = 0;
        while (taken < PHASE_ITEMS) begin
          req = random_request();
          send_request(req);
          // Count only requests that make the block answer
          if (!(req.mode == MODE_ALLOC && req.batch_count == 0)) taken++;
        end
        no_idle = 1'b0;
        wait_idle();
      end
    end
  endtask

  // Fill the whole pool, hit full at the top, then reuse freed ids in LIFO order
  task automatic test_fill_pool();
    int unsigned live;
    int unsigned n;
    begin
      write_limit(11'd1024);
      live = shadow_high_mark - shadow_depth;
      while (live < POOL_SIZE_DEF) begin
        n = POOL_SIZE_DEF - live;
        if (n > MAX_BATCH_DEF) n = MAX_BATCH_DEF;
        send_request(make_alloc(n));
        live = shadow_high_mark - shadow_depth;
      end
      send_request(make_alloc(1));        // pool exhausted
      send_request(make_free(1023));
      send_request(make_free(512));
      send_request(make_free(1023));      // already free
      send_request(make_alloc(2));        // 512 then 1023
      send_request(make_alloc(1));        // full again
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    no_idle          = 1'b0;
    sink_hold_cycles = 0;
    errors           = 0;
    n_requests       = 0;
    n_results        = 0;
    n_full           = 0;
    n_rejected_frees = 0;
    shadow_limit     = MAX_LIVE_RESET;
    shadow_high_mark = 0;
    shadow_depth     = 0;
    foreach (shadow_live[i]) shadow_live[i] = 1'b0;
    foreach (shadow_stack[i]) shadow_stack[i] = '0;

    // Hold reset, then release it away from the sampling edge
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_basic_ops();
    test_limit_edges();
    test_backpressure();
    test_random_traffic();
    test_fill_pool();

    $display("Covered %0d requests and %0d results: %0d full, %0d rejected frees.",
             n_requests, n_results, n_full, n_rejected_frees);
    $display("Limits from 0 to above the pool, LIFO reuse, a filled pool, sink hold-off.");
    if (errors == 0 && expected_grants.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(RUN_LIMIT);
    $display("Timeout with %0d results still owed", expected_grants.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
